>>> hw/rtl/fsa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fsa_pkg
// Shared types and fixed field widths for the frame-tagged slot allocator.
// ----------------------------------------------------------------------------
package fsa_pkg;

  localparam int FRAME_W      = 16;
  localparam int LAYOUT_ID_W  = 2;
  localparam int SLOT_INDEX_W = 5;

  // request opcodes
  typedef enum logic {
    CMD_ACQUIRE = 1'b0,
    CMD_UPDATE  = 1'b1
  } cmd_t;

  // sequencer states
  typedef enum logic [3:0] {
    S_IDLE,
    S_CNT_RD,
    S_CNT_CHK,
    S_ROW_RD,
    S_A_ROW_CHK,
    S_A_OPEN,
    S_U_ROW_CAP,
    S_U_SCAN,
    S_U_WB,
    S_U_NEXT,
    S_FINISH
  } state_t;

  typedef struct packed {
    cmd_t                   command;
    logic [LAYOUT_ID_W-1:0] layout_id;
    logic [FRAME_W-1:0]     current_frame;
    logic [FRAME_W-1:0]     release_frame;
  } req_word_t;

  typedef struct packed {
    logic [SLOT_INDEX_W-1:0] slot_index;
    logic                    opens_pool;
    logic                    exhausted;
    logic                    update_done;
  } rsp_word_t;

endpackage

>>> hw/rtl/frame_tagged_slot_allocator_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frame_tagged_slot_allocator_unit
// Bitmap slot allocator with per-slot frame tags and frame-based release.
//
//   channel | valid     | stall     | word
//   --------+-----------+-----------+---------------------------------------
//   request | req_valid | req_stall | req: command, layout_id, frames
//   result  | rsp_valid | rsp_stall | rsp: slot_index, opens_pool, flags
//
// One request at a time; req_stall is high from accept until the result is
// loaded into the output register. Acquire reads the layout's pool count,
// checks the rows of the opened pools in order until one has a free slot,
// and opens a new pool if none has and MAX_POOLS allows. Frame update scans
// every opened pool of every layout via the one-tag-per-cycle tag RAM port.
// Free bitmaps and tags need no clearing pass: a pool's row is written when
// the pool opens, and only opened pools are read. Per-layout pool counts
// carry flop valid bits cleared by rst. A waiting result does not block the
// next accept; a result waits in FINISH while rsp_valid && rsp_stall.
// ----------------------------------------------------------------------------
module frame_tagged_slot_allocator_unit #(
  parameter int SLOTS_PER_POOL = 8,
  parameter int MAX_POOLS      = 4,
  parameter int NUM_LAYOUTS    = 4
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_stall,
  input  fsa_pkg::req_word_t req,
  output logic              rsp_valid,
  input  logic              rsp_stall,
  output fsa_pkg::rsp_word_t rsp
);

  import fsa_pkg::*;

  localparam int SPP  = SLOTS_PER_POOL;
  localparam int LW   = (NUM_LAYOUTS > 1) ? $clog2(NUM_LAYOUTS) : 1;
  localparam int PW   = (MAX_POOLS > 1) ? $clog2(MAX_POOLS) : 1;
  localparam int OW   = $clog2(MAX_POOLS + 1);
  localparam int SW   = (SPP > 1) ? $clog2(SPP) : 1;
  localparam int ROWS = NUM_LAYOUTS * MAX_POOLS;
  localparam int RW   = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int TAGS = ROWS * SPP;
  localparam int TW   = (TAGS > 1) ? $clog2(TAGS) : 1;

  state_t state, state_next;

  // working registers
  cmd_t                cmd;
  logic [LW-1:0]       layer;
  logic [PW-1:0]       pool;
  logic [SW-1:0]       slot;
  logic [OW-1:0]       opened;
  logic [SPP-1:0]      row;
  logic [FRAME_W-1:0]  rel;
  logic [FRAME_W-1:0]  frame_now;
  rsp_word_t           res;
  logic [NUM_LAYOUTS-1:0] cnt_valid;

  // RAM ports
  logic                free_we;
  logic [SPP-1:0]      free_wdata, free_rdata;
  logic                tag_we;
  logic [TW-1:0]       tag_waddr, tag_raddr;
  logic [FRAME_W-1:0]  tag_rdata;
  logic                cnt_we;
  logic [OW-1:0]       cnt_wdata, cnt_rdata;

  // derived control
  logic [RW-1:0]       row_addr;
  logic [SW-1:0]       tag_rslot, tag_wslot;
  logic                hit;
  logic [SW-1:0]       hit_slot;
  logic                tag_match;
  logic [OW-1:0]       cnt_opened;
  logic                cnt_full, last_pool, last_slot, last_layer, lay_bad;

  // address and compare logic
  assign row_addr   = RW'(int'(layer) * MAX_POOLS + int'(pool));
  assign tag_rslot  = (state == S_U_SCAN) ? SW'(slot + SW'(1)) : slot;
  assign tag_wslot  = (state == S_A_OPEN) ? '0 : hit_slot;
  assign tag_raddr  = TW'(int'(row_addr) * SLOTS_PER_POOL + int'(tag_rslot));
  assign tag_waddr  = TW'(int'(row_addr) * SLOTS_PER_POOL + int'(tag_wslot));
  assign tag_match  = (tag_rdata == rel);
  assign cnt_opened = cnt_valid[layer] ? cnt_rdata : '0;
  assign cnt_full   = (opened >= OW'(MAX_POOLS));
  assign last_pool  = (OW'(int'(pool) + 1) >= opened);
  assign last_slot  = (slot == SW'(SLOTS_PER_POOL - 1));
  assign last_layer = (layer == LW'(NUM_LAYOUTS - 1));
  assign lay_bad    = (int'(req.layout_id) >= NUM_LAYOUTS);
  assign cnt_wdata  = OW'(int'(opened) + 1);

  // lowest free slot of the row just read
  always_comb begin
    hit      = 1'b0;
    hit_slot = '0;
    for (int i = SPP - 1; i >= 0; i--) begin
      if (free_rdata[i]) begin
        hit      = 1'b1;
        hit_slot = SW'(i);
      end
    end
  end

  // free row write data: fresh pool, write-back of a scanned row, or a grant
  always_comb begin
    priority if (state == S_A_OPEN) begin
      free_wdata = ~SPP'(1);
    end else if (state == S_U_WB) begin
      free_wdata = row;
    end else begin
      free_wdata = free_rdata & ~(SPP'(1) << hit_slot);
    end
  end

  // sequencer state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and RAM strobes
  always_comb begin
    state_next = state;
    free_we    = 1'b0;
    tag_we     = 1'b0;
    cnt_we     = 1'b0;
    req_stall  = (state != S_IDLE);
    unique case (state)
      S_IDLE: begin
        if (req_valid) begin
          if (req.command == CMD_ACQUIRE && lay_bad) begin
            state_next = S_FINISH;
          end else begin
            state_next = S_CNT_RD;
          end
        end
      end
      S_CNT_RD: state_next = S_CNT_CHK;
      S_CNT_CHK: begin
        if (cnt_opened != '0) begin
          state_next = S_ROW_RD;
        end else if (cmd == CMD_ACQUIRE) begin
          state_next = S_A_OPEN;
        end else begin
          state_next = S_U_NEXT;
        end
      end
      S_ROW_RD: state_next = (cmd == CMD_ACQUIRE) ? S_A_ROW_CHK : S_U_ROW_CAP;
      S_A_ROW_CHK: begin
        if (hit) begin
          free_we    = 1'b1;
          tag_we     = 1'b1;
          state_next = S_FINISH;
        end else if (last_pool) begin
          state_next = S_A_OPEN;
        end else begin
          state_next = S_ROW_RD;
        end
      end
      S_A_OPEN: begin
        if (!cnt_full) begin
          free_we = 1'b1;
          tag_we  = 1'b1;
          cnt_we  = 1'b1;
        end
        state_next = S_FINISH;
      end
      S_U_ROW_CAP: state_next = S_U_SCAN;
      S_U_SCAN: begin
        if (last_slot) begin
          state_next = S_U_WB;
        end
      end
      S_U_WB: begin
        free_we    = 1'b1;
        state_next = last_pool ? S_U_NEXT : S_ROW_RD;
      end
      S_U_NEXT: state_next = last_layer ? S_FINISH : S_CNT_RD;
      S_FINISH: begin
        if (!rsp_valid || !rsp_stall) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // control registers with reset
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
      cnt_valid <= '0;
      frame_now <= '0;
    end else begin
      if (state == S_FINISH && (!rsp_valid || !rsp_stall)) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
      if (cnt_we) begin
        cnt_valid[layer] <= 1'b1;
      end
      if (state == S_IDLE && req_valid && req.command == CMD_UPDATE) begin
        frame_now <= req.current_frame;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (state == S_FINISH && (!rsp_valid || !rsp_stall)) begin
      rsp <= res;
    end
    unique case (state)
      S_IDLE: begin
        if (req_valid) begin
          cmd             <= req.command;
          layer           <= (req.command == CMD_ACQUIRE) ? LW'(req.layout_id) : '0;
          rel             <= req.release_frame;
          res.slot_index  <= '0;
          res.opens_pool  <= 1'b0;
          res.exhausted   <= (req.command == CMD_ACQUIRE) && lay_bad;
          res.update_done <= (req.command == CMD_UPDATE);
        end
      end
      S_CNT_CHK: begin
        opened <= cnt_opened;
        pool   <= '0;
      end
      S_ROW_RD: slot <= '0;
      S_A_ROW_CHK: begin
        if (hit) begin
          res.slot_index <=
            SLOT_INDEX_W'(int'(pool) * SLOTS_PER_POOL + int'(hit_slot));
        end else if (!last_pool) begin
          pool <= PW'(int'(pool) + 1);
        end else begin
          pool <= PW'(opened);
        end
      end
      S_A_OPEN: begin
        if (!cnt_full) begin
          res.slot_index <= SLOT_INDEX_W'(int'(opened) * SLOTS_PER_POOL);
          res.opens_pool <= 1'b1;
        end else begin
          res.exhausted  <= 1'b1;
        end
      end
      S_U_ROW_CAP: row <= free_rdata;
      S_U_SCAN: begin
        // free a used slot whose tag matches the release frame
        if (!row[slot] && tag_match) begin
          row[slot] <= 1'b1;
        end
        slot <= SW'(slot + SW'(1));
      end
      S_U_WB: begin
        if (!last_pool) begin
          pool <= PW'(int'(pool) + 1);
        end
      end
      S_U_NEXT: layer <= LW'(int'(layer) + 1);
      default: ;
    endcase
  end

  // free bitmap, one row per layout and pool
  fsa_ram #(
    .WIDTH (SPP),
    .DEPTH (ROWS)
  ) u_free_ram (
    .clk   (clk),
    .we    (free_we),
    .waddr (row_addr),
    .wdata (free_wdata),
    .raddr (row_addr),
    .rdata (free_rdata)
  );

  // frame tag per slot
  fsa_ram #(
    .WIDTH (FRAME_W),
    .DEPTH (TAGS)
  ) u_tag_ram (
    .clk   (clk),
    .we    (tag_we),
    .waddr (tag_waddr),
    .wdata (frame_now),
    .raddr (tag_raddr),
    .rdata (tag_rdata)
  );

  // pools opened per layout
  fsa_ram #(
    .WIDTH (OW),
    .DEPTH (NUM_LAYOUTS)
  ) u_cnt_ram (
    .clk   (clk),
    .we    (cnt_we),
    .waddr (layer),
    .wdata (cnt_wdata),
    .raddr (layer),
    .rdata (cnt_rdata)
  );

  // checks
  a_row_in_range: assert property (@(posedge clk) disable iff (rst)
    state == S_A_ROW_CHK |-> OW'(pool) < opened)
    else $error("row check on a pool that is not open");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    cnt_we |-> cnt_wdata <= OW'(MAX_POOLS))
    else $error("pool count beyond MAX_POOLS");

  a_open_clean: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.opens_pool |-> !rsp.exhausted && !rsp.update_done)
    else $error("pool open word carries other flags");

  a_scan_exit: assert property (@(posedge clk) disable iff (rst)
    state == S_U_SCAN && last_slot |=> state == S_U_WB)
    else $error("tag scan did not end in write-back");

endmodule

>>> hw/rtl/fsa_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fsa_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module fsa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule
